@@ src/source_text_tokenizer_unit_defines.svh @@
// Assertion macros shared by the tokenizer RTL.
`ifndef SOURCE_TEXT_TOKENIZER_UNIT_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_UNIT_DEFINES_SVH

// Condition must hold at every edge out of reset.
`define STT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define STT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/stt_pkg.sv @@
// Shared types, character codes and token kinds of the source text tokenizer.
package stt_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int TOK_W             = 16;
  localparam int KIND_W            = 5;
  localparam int MAX_TOKENS        = 3;

  localparam logic [TOK_W-1:0] LINE_MAX = '1;

  // characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // token kinds
  localparam logic [KIND_W-1:0] KIND_LPAREN  = 5'd0;
  localparam logic [KIND_W-1:0] KIND_RPAREN  = 5'd1;
  localparam logic [KIND_W-1:0] KIND_LBRACE  = 5'd2;
  localparam logic [KIND_W-1:0] KIND_RBRACE  = 5'd3;
  localparam logic [KIND_W-1:0] KIND_SEMI    = 5'd4;
  localparam logic [KIND_W-1:0] KIND_COMMA   = 5'd5;
  localparam logic [KIND_W-1:0] KIND_DOT     = 5'd6;
  localparam logic [KIND_W-1:0] KIND_MINUS   = 5'd7;
  localparam logic [KIND_W-1:0] KIND_PLUS    = 5'd8;
  localparam logic [KIND_W-1:0] KIND_SLASH   = 5'd9;
  localparam logic [KIND_W-1:0] KIND_STAR    = 5'd10;
  localparam logic [KIND_W-1:0] KIND_BANG    = 5'd11;  // first operator, '=' form is +1
  localparam logic [KIND_W-1:0] KIND_STRING  = 5'd19;
  localparam logic [KIND_W-1:0] KIND_NUMBER  = 5'd20;
  localparam logic [KIND_W-1:0] KIND_END     = 5'd21;
  localparam logic [KIND_W-1:0] KIND_UNEXP   = 5'd22;
  localparam logic [KIND_W-1:0] KIND_UNTERM  = 5'd23;

  // pending operator codes
  localparam logic [1:0] OP_BANG = 2'd0;
  localparam logic [1:0] OP_EQ   = 2'd1;
  localparam logic [1:0] OP_LT   = 2'd2;
  localparam logic [1:0] OP_GT   = 2'd3;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_SLASH,
    MODE_COMMENT,
    MODE_OPER,
    MODE_NUMBER,
    MODE_NUMDOT,
    MODE_FRACTION,
    MODE_STRING
  } mode_e;

  typedef struct packed {
    logic [TOK_W-1:0]  line;
    logic [TOK_W-1:0]  length;
    logic [TOK_W-1:0]  start;
    logic [KIND_W-1:0] kind;
  } tok_t;

  // tokens caused by one source byte, slot 0 first
  typedef struct packed {
    tok_t [MAX_TOKENS-1:0] tok;
    logic [1:0]            cnt;
  } tok_grp_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  // single-character punctuator kind, KIND_UNEXP when none matches
  function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] c);
    logic [KIND_W-1:0] k;
    case (c)
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_SEMI:   k = KIND_SEMI;
      CH_COMMA:  k = KIND_COMMA;
      CH_DOT:    k = KIND_DOT;
      CH_MINUS:  k = KIND_MINUS;
      CH_PLUS:   k = KIND_PLUS;
      CH_SLASH:  k = KIND_SLASH;
      CH_STAR:   k = KIND_STAR;
      default:   k = KIND_UNEXP;
    endcase
    return k;
  endfunction

endpackage

@@ src/stt_scan_core.sv @@
// Scanner state and per-byte token decision logic.
`include "source_text_tokenizer_unit_defines.svh"

module stt_scan_core import stt_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output tok_grp_t   grp_o
);

  localparam int PB = POSITION_BITS;

  mode_e            mode_q, mode_d;
  logic [1:0]       pend_q, pend_d;
  logic [PB-1:0]    start_q, start_d;
  logic [PB-1:0]    pos_q, pos_d;
  logic [TOK_W-1:0] line_q, line_d;

  // mode-side results
  logic          pass;
  logic [1:0]    m_n;
  tok_t          m_a, m_b;
  logic          str_nl;
  // between-tokens side results
  logic          i_v;
  tok_t          i_t;
  mode_e         i_mode;
  logic          i_set_start;
  logic [1:0]    i_pend;
  logic          i_pend_v;

  logic [PB-1:0] sp_pos, dot_pos, sp_dot;
  logic [PB:0]   sp_pos_p1;
  logic [KIND_W-1:0] op_kind;
  logic          dig;

  function automatic logic [PB-1:0] span_f(input logic [PB-1:0] e, input logic [PB-1:0] s);
    return (e >= s) ? (e - s) : '0;
  endfunction

  function automatic tok_t mk_tok(input logic [KIND_W-1:0] k, input logic [PB-1:0] s,
                                  input logic [TOK_W-1:0] len, input logic [TOK_W-1:0] ln);
    tok_t t;
    t.kind   = k;
    t.start  = TOK_W'(s);
    t.length = len;
    t.line   = ln;
    return t;
  endfunction

  assign dig       = is_digit(byte_i);
  assign sp_pos    = span_f(pos_q, start_q);
  assign sp_pos_p1 = {1'b0, sp_pos} + (PB+1)'(1);
  assign dot_pos   = (pos_q > start_q) ? (pos_q - PB'(1)) : start_q;
  assign sp_dot    = span_f(dot_pos, start_q);
  assign op_kind   = KIND_BANG + {2'b00, pend_q, 1'b0};

  // tokens closed by the current mode, and whether the byte is rescanned
  always_comb begin
    pass   = 1'b1;
    m_n    = 2'd0;
    m_a    = '0;
    m_b    = '0;
    str_nl = 1'b0;
    unique case (mode_q) inside
      MODE_SLASH: begin
        if (byte_i == CH_SLASH) begin
          pass = 1'b0;
        end else begin
          m_n = 2'd1;
          m_a = mk_tok(KIND_SLASH, start_q, TOK_W'(1), line_q);
        end
      end
      MODE_COMMENT: begin
        if (byte_i != CH_LF && byte_i != CH_NUL) pass = 1'b0;
      end
      MODE_OPER: begin
        m_n = 2'd1;
        if (byte_i == CH_EQ) begin
          pass = 1'b0;
          m_a  = mk_tok(op_kind + KIND_W'(1), start_q, TOK_W'(2), line_q);
        end else begin
          m_a  = mk_tok(op_kind, start_q, TOK_W'(1), line_q);
        end
      end
      MODE_NUMBER, MODE_FRACTION: begin
        if (dig || (mode_q == MODE_NUMBER && byte_i == CH_DOT)) begin
          pass = 1'b0;
        end else begin
          m_n = 2'd1;
          m_a = mk_tok(KIND_NUMBER, start_q, TOK_W'(sp_pos), line_q);
        end
      end
      MODE_NUMDOT: begin
        if (dig) begin
          pass = 1'b0;
        end else begin
          // "12." with no fraction: number, then the dot on its own
          m_n = 2'd2;
          m_a = mk_tok(KIND_NUMBER, start_q, TOK_W'(sp_dot), line_q);
          m_b = mk_tok(KIND_DOT, dot_pos, TOK_W'(1), line_q);
        end
      end
      MODE_STRING: begin
        if (byte_i == CH_QUOTE) begin
          pass = 1'b0;
          m_n  = 2'd1;
          m_a  = mk_tok(KIND_STRING, start_q, TOK_W'(sp_pos_p1), line_q);
        end else if (byte_i == CH_NUL) begin
          m_n  = 2'd1;
          m_a  = mk_tok(KIND_UNTERM, start_q, TOK_W'(sp_pos), line_q);
        end else begin
          pass   = 1'b0;
          str_nl = (byte_i == CH_LF);
        end
      end
      default: ;
    endcase
  end

  // scan of a byte between tokens
  always_comb begin
    i_v         = 1'b0;
    i_t         = '0;
    i_mode      = MODE_IDLE;
    i_set_start = 1'b0;
    i_pend      = OP_BANG;
    i_pend_v    = 1'b0;
    if (byte_i == CH_NUL) begin
      i_v = 1'b1;
      i_t = mk_tok(KIND_END, pos_q, '0, line_q);
    end else if (dig) begin
      i_mode      = MODE_NUMBER;
      i_set_start = 1'b1;
    end else begin
      case (byte_i) inside
        CH_SPACE, CH_CR, CH_TAB, CH_LF: ;
        CH_SLASH: begin
          i_mode      = MODE_SLASH;
          i_set_start = 1'b1;
        end
        CH_QUOTE: begin
          i_mode      = MODE_STRING;
          i_set_start = 1'b1;
        end
        CH_BANG, CH_EQ, CH_LT, CH_GT: begin
          i_mode      = MODE_OPER;
          i_set_start = 1'b1;
          i_pend_v    = 1'b1;
          case (byte_i)
            CH_BANG: i_pend = OP_BANG;
            CH_EQ:   i_pend = OP_EQ;
            CH_LT:   i_pend = OP_LT;
            default: i_pend = OP_GT;
          endcase
        end
        default: begin
          i_v = 1'b1;
          i_t = mk_tok(punct_kind(byte_i), pos_q, TOK_W'(1), line_q);
        end
      endcase
    end
  end

  // next state
  always_comb begin
    mode_d  = mode_q;
    pend_d  = pend_q;
    start_d = start_q;
    line_d  = line_q;
    unique case (mode_q)
      MODE_SLASH:    mode_d = (byte_i == CH_SLASH) ? MODE_COMMENT : MODE_IDLE;
      MODE_COMMENT:  mode_d = pass ? MODE_IDLE : MODE_COMMENT;
      MODE_NUMBER:   mode_d = dig ? MODE_NUMBER : (byte_i == CH_DOT) ? MODE_NUMDOT : MODE_IDLE;
      MODE_NUMDOT:   mode_d = dig ? MODE_FRACTION : MODE_IDLE;
      MODE_FRACTION: mode_d = dig ? MODE_FRACTION : MODE_IDLE;
      MODE_STRING:   mode_d = pass ? MODE_IDLE : (byte_i == CH_QUOTE) ? MODE_IDLE : MODE_STRING;
      default:       mode_d = MODE_IDLE;
    endcase
    if (str_nl && line_q != LINE_MAX) line_d = line_q + TOK_W'(1);
    if (pass) begin
      mode_d = i_mode;
      if (i_set_start) start_d = pos_q;
      if (i_pend_v) pend_d = i_pend;
      if (byte_i == CH_LF && line_q != LINE_MAX) line_d = line_q + TOK_W'(1);
    end
    if (byte_i == CH_NUL) begin
      // every path reaches the end token on a zero byte
      pos_d   = '0;
      start_d = '0;
      line_d  = TOK_W'(1);
    end else if (pos_q != '1) begin
      pos_d = pos_q + PB'(1);
    end else begin
      pos_d = pos_q;
    end
  end

  // pack mode tokens first, then the rescan token
  always_comb begin
    grp_o.tok = '0;
    grp_o.cnt = m_n + {1'b0, pass & i_v};
    unique case (m_n)
      2'd0: grp_o.tok[0] = i_t;
      2'd1: begin
        grp_o.tok[0] = m_a;
        grp_o.tok[1] = i_t;
      end
      default: begin
        grp_o.tok[0] = m_a;
        grp_o.tok[1] = m_b;
        grp_o.tok[2] = i_t;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pend_q  <= OP_BANG;
      start_q <= '0;
      pos_q   <= '0;
      line_q  <= TOK_W'(1);
    end else if (step_i) begin
      mode_q  <= mode_d;
      pend_q  <= pend_d;
      start_q <= start_d;
      pos_q   <= pos_d;
      line_q  <= line_d;
    end
  end

  `STT_ASSERT_ALWAYS(a_line_nonzero, line_q != '0, "line count reached zero")
  `STT_ASSERT_IMP(a_three_only_numdot, step_i && grp_o.cnt == 2'd3,
                  mode_q == MODE_NUMDOT, "three tokens outside number-dot")
  `STT_ASSERT_NEXT(a_end_restarts, step_i && byte_i == CH_NUL,
                   pos_q == '0 && line_q == TOK_W'(1) && mode_q == MODE_IDLE,
                   "end of source did not restart scanner")

endmodule

@@ src/stt_tok_buf.sv @@
// Result register holding one byte's tokens and handing them out one per transfer.
`include "source_text_tokenizer_unit_defines.svh"

module stt_tok_buf import stt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  tok_grp_t grp_i,
  output logic     free_o,
  output logic     valid_o,
  input  logic     ready_i,
  output tok_t     tok_o,
  output logic     last_o
);

  tok_t [MAX_TOKENS-1:0] tok_q;
  logic [1:0]            cnt_q, cnt_d;
  logic [1:0]            idx_q, idx_d;

  assign valid_o = idx_q < cnt_q;
  assign last_o  = idx_q == (cnt_q - 2'd1);
  assign free_o  = !valid_o || (ready_i && last_o);

  always_comb begin
    case (idx_q)
      2'd1:    tok_o = tok_q[1];
      2'd2:    tok_o = tok_q[2];
      default: tok_o = tok_q[0];
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_i) begin
      cnt_d = grp_i.cnt;
      idx_d = '0;
    end else if (valid_o && ready_i) begin
      if (last_o) begin
        cnt_d = '0;
        idx_d = '0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) tok_q <= grp_i.tok;
  end

  `STT_ASSERT_IMP(a_load_when_free, load_i, free_o, "tokens loaded over undelivered ones")
  `STT_ASSERT_NEXT(a_empty_load, load_i && grp_i.cnt == 2'd0, !valid_o, "empty group shows a token")

endmodule

@@ src/source_text_tokenizer_unit.sv @@
// Top level of the streaming source text tokenizer.
//
// Source text enters one byte per transfer on the s_axis side and tokens leave one per
// transfer on the m_axis side, each with kind, start offset, length and line; tlast marks
// the last token caused by one byte. A zero byte ends the source: pending tokens are sent,
// then the end token, and offset and line restart at 0 and 1. A byte sits in an input
// register, the scanner decides its zero to three tokens combinationally, and they wait
// in a result register that is drained one token per cycle while m_axis_tready is high.
// A byte that yields at most one token lets the input keep up at one byte per cycle while
// the sink is ready; a byte yielding more tokens holds the scanner until its last is taken.

module source_text_tokenizer_unit import stt_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] source_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [4:0] token_kind, [20:5] start_offset,
                                      // [36:21] token_length, [52:37] line_number, rest 0
  output logic        m_axis_tlast    // last_of_run
);

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       advance;

  tok_grp_t grp;
  logic     buf_free;
  tok_t     tok_out;

  // the held byte is scanned once the result register can take its tokens
  assign advance       = in_vld_q && buf_free;
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) in_byte_q <= s_axis_tdata;
  end

  stt_scan_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .grp_o  (grp)
  );

  stt_tok_buf u_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance),
    .grp_i   (grp),
    .free_o  (buf_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .tok_o   (tok_out),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, tok_out.line, tok_out.length, tok_out.start, tok_out.kind};

endmodule

@@ tb/tb_source_text_tokenizer_unit.sv @@
`timescale 1ns / 1ps
// Testbench of the source text tokenizer: directed table, random source text, token predictor.
module tb_source_text_tokenizer_unit;
  import stt_pkg::*;

  localparam int          CLK_PERIOD   = 10;
  localparam int          POS_BITS     = POSITION_BITS_DEF;
  localparam logic [31:0] POS_LIMIT    = (32'd1 << POS_BITS) - 32'd1;
  localparam int          CYCLE_LIMIT  = 200_000;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          TABLE_ROWS   = 25;
  localparam int          RANDOM_BYTES = 400;
  localparam int          CALM_BYTES   = 80;     // no idling over the tail of the random part

  localparam logic [10:0][7:0] PUNCT_CHARS = {CH_STAR, CH_SLASH, CH_PLUS, CH_MINUS, CH_DOT,
                                              CH_COMMA, CH_SEMI, CH_RBRACE, CH_LBRACE,
                                              CH_RPAREN, CH_LPAREN};
  localparam logic [3:0][7:0]  OPER_CHARS  = {CH_GT, CH_LT, CH_EQ, CH_BANG};

  typedef struct packed {
    logic last;
    tok_t tok;
  } token_t;

  // One row of the directed table; fixed rows carry the single token they must produce.
  typedef struct packed {
    logic [7:0]        ch;
    logic              fixed;
    logic [KIND_W-1:0] kind;
    logic [15:0]       start;
    logic [15:0]       length;
    logic [15:0]       line;
  } stim_row_t;

  localparam stim_row_t STIM_TABLE [TABLE_ROWS] = '{
    '{CH_LPAREN,    1'b1, KIND_LPAREN, 16'd0, 16'd1, 16'd1},  // first token after reset
    '{CH_TAB,       1'b0, '0, '0, '0, '0},
    '{8'hFF,        1'b1, KIND_UNEXP,  16'd2, 16'd1, 16'd1},  // top byte value is unexpected
    '{CH_0 + 8'd1,  1'b0, '0, '0, '0, '0},
    '{CH_0 + 8'd2,  1'b0, '0, '0, '0, '0},
    '{CH_DOT,       1'b0, '0, '0, '0, '0},
    '{CH_SEMI,      1'b0, '0, '0, '0, '0},                    // number, lone dot, semicolon
    '{CH_GT,        1'b0, '0, '0, '0, '0},
    '{CH_EQ,        1'b0, '0, '0, '0, '0},
    '{CH_QUOTE,     1'b0, '0, '0, '0, '0},
    '{CH_LF,        1'b0, '0, '0, '0, '0},                    // newline inside a string
    '{CH_QUOTE,     1'b0, '0, '0, '0, '0},
    '{CH_SLASH,     1'b0, '0, '0, '0, '0},
    '{CH_STAR,      1'b0, '0, '0, '0, '0},
    '{CH_SLASH,     1'b0, '0, '0, '0, '0},
    '{CH_SLASH,     1'b0, '0, '0, '0, '0},
    '{8'h80,        1'b0, '0, '0, '0, '0},                    // high byte swallowed by comment
    '{CH_LF,        1'b0, '0, '0, '0, '0},
    '{CH_0 + 8'd3,  1'b0, '0, '0, '0, '0},
    '{CH_DOT,       1'b0, '0, '0, '0, '0},
    '{CH_0 + 8'd5,  1'b0, '0, '0, '0, '0},
    '{CH_BANG,      1'b0, '0, '0, '0, '0},
    '{CH_QUOTE,     1'b0, '0, '0, '0, '0},
    '{CH_NUL,       1'b0, '0, '0, '0, '0},                    // unterminated string, then end
    '{CH_NUL,       1'b1, KIND_END,    16'd0, 16'd0, 16'd1}   // empty source
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;

  // predictor state
  mode_e       lex_mode;
  logic [1:0]  lex_op;
  logic [31:0] lex_start;
  logic [31:0] lex_pos;
  logic [15:0] lex_line;
  token_t      tokens_of_byte [$];

  token_t      expected_tokens [$];
  token_t      seen_token;
  token_t      want_token;
  int          fails          = 0;
  int          bytes_sent     = 0;
  int          cycles         = 0;
  int          src_gap_pct    = 0;
  int          sink_stall_pct = 0;
  int          sink_hold      = 0;

  source_text_tokenizer_unit i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------

  function automatic logic is_numeral(input logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  // length from the token start up to (not including) stop, never negative
  function automatic logic [31:0] span_to(input logic [31:0] stop);
    return (stop >= lex_start) ? stop - lex_start : 32'd0;
  endfunction

  task automatic emit_token(input logic [KIND_W-1:0] kind, input logic [31:0] start,
                            input logic [31:0] length);
    token_t t;
    t.last       = 1'b0;
    t.tok.kind   = kind;
    t.tok.start  = start[15:0];
    t.tok.length = length[15:0];
    t.tok.line   = lex_line;
    tokens_of_byte.push_back(t);
  endtask

  task automatic reset_scanner();
    lex_mode  = MODE_IDLE;
    lex_op    = OP_BANG;
    lex_start = '0;
    lex_pos   = '0;
    lex_line  = 16'd1;
  endtask

  // a byte seen with nothing pending
  task automatic scan_fresh(input logic [7:0] c);
    logic hit;
    lex_mode = MODE_IDLE;
    hit      = 1'b0;
    if (c == CH_NUL) begin
      emit_token(KIND_END, lex_pos, 32'd0);
      lex_pos   = '0;
      lex_line  = 16'd1;
      lex_start = '0;
    end else if (is_numeral(c)) begin
      lex_start = lex_pos;
      lex_mode  = MODE_NUMBER;
    end else begin
      case (c) inside
        CH_SPACE, CH_CR, CH_TAB: ;
        CH_LF: if (lex_line != LINE_MAX) lex_line++;
        CH_SLASH: begin
          lex_start = lex_pos;
          lex_mode  = MODE_SLASH;
        end
        CH_QUOTE: begin
          lex_start = lex_pos;
          lex_mode  = MODE_STRING;
        end
        CH_BANG, CH_EQ, CH_LT, CH_GT: begin
          lex_op    = (c == CH_BANG) ? OP_BANG : (c == CH_EQ) ? OP_EQ :
                      (c == CH_LT)   ? OP_LT   : OP_GT;
          lex_start = lex_pos;
          lex_mode  = MODE_OPER;
        end
        default: begin
          for (int k = 0; k < 11; k++) begin
            if (!hit && PUNCT_CHARS[k[3:0]] == c) begin
              emit_token(k[KIND_W-1:0], lex_pos, 32'd1);
              hit = 1'b1;
            end
          end
          if (!hit) emit_token(KIND_UNEXP, lex_pos, 32'd1);
        end
      endcase
    end
  endtask

  // Works out the tokens caused by one accepted byte into tokens_of_byte.
  task automatic scan_source_byte(input logic [7:0] c);
    logic              fresh;
    logic [KIND_W-1:0] op_kind;
    logic [31:0]       dot_at;
    token_t            t;
    fresh   = 1'b1;
    op_kind = KIND_BANG + {2'b00, lex_op, 1'b0};
    tokens_of_byte.delete();
    case (lex_mode)
      MODE_SLASH: begin
        if (c == CH_SLASH) begin
          lex_mode = MODE_COMMENT;
          fresh    = 1'b0;
        end else begin
          emit_token(KIND_SLASH, lex_start, 32'd1);
        end
      end
      MODE_COMMENT: if (c != CH_LF && c != CH_NUL) fresh = 1'b0;
      MODE_OPER: begin
        if (c == CH_EQ) begin
          emit_token(op_kind + 5'd1, lex_start, 32'd2);
          lex_mode = MODE_IDLE;
          fresh    = 1'b0;
        end else begin
          emit_token(op_kind, lex_start, 32'd1);
        end
      end
      MODE_NUMBER: begin
        if (is_numeral(c)) begin
          fresh = 1'b0;
        end else if (c == CH_DOT) begin
          lex_mode = MODE_NUMDOT;
          fresh    = 1'b0;
        end else begin
          emit_token(KIND_NUMBER, lex_start, span_to(lex_pos));
        end
      end
      MODE_NUMDOT: begin
        if (is_numeral(c)) begin
          lex_mode = MODE_FRACTION;
          fresh    = 1'b0;
        end else begin
          // no fraction after all: the dot goes out as its own token
          dot_at = (lex_pos > lex_start) ? lex_pos - 32'd1 : lex_start;
          emit_token(KIND_NUMBER, lex_start, span_to(dot_at));
          emit_token(KIND_DOT, dot_at, 32'd1);
        end
      end
      MODE_FRACTION: begin
        if (is_numeral(c)) fresh = 1'b0;
        else emit_token(KIND_NUMBER, lex_start, span_to(lex_pos));
      end
      MODE_STRING: begin
        if (c == CH_QUOTE) begin
          emit_token(KIND_STRING, lex_start, span_to(lex_pos) + 32'd1);
          lex_mode = MODE_IDLE;
          fresh    = 1'b0;
        end else if (c == CH_NUL) begin
          emit_token(KIND_UNTERM, lex_start, span_to(lex_pos));
        end else begin
          if (c == CH_LF && lex_line != LINE_MAX) lex_line++;
          fresh = 1'b0;
        end
      end
      default: ;
    endcase
    if (fresh) scan_fresh(c);
    if (c != CH_NUL && lex_pos < POS_LIMIT) lex_pos++;
    if (tokens_of_byte.size() > 0) begin
      t      = tokens_of_byte.pop_back();
      t.last = 1'b1;
      tokens_of_byte.push_back(t);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Source side
  // ---------------------------------------------------------------------------

  // Offers one byte, waits for the transfer, then books its tokens. A fixed row books
  // its own token instead of the predicted ones.
  task automatic send_byte(input logic [7:0] b, input logic fixed, input token_t fixed_tok);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    scan_source_byte(b);
    if (fixed) expected_tokens.push_back(fixed_tok);
    else foreach (tokens_of_byte[i]) expected_tokens.push_back(tokens_of_byte[i]);
    if ($urandom_range(0, 99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // One random lexeme, mostly well formed; the rest is noise and broken input.
  task automatic send_lexeme();
    int         pick;
    int         n;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      send_byte(PUNCT_CHARS[4'($urandom_range(0, 10))], 1'b0, '0);
    end else if (pick < 30) begin
      send_byte(OPER_CHARS[2'($urandom_range(0, 3))], 1'b0, '0);
      if ($urandom_range(0, 1) == 1) send_byte(CH_EQ, 1'b0, '0);
    end else if (pick < 45) begin
      n = $urandom_range(1, 4);
      repeat (n) send_byte(CH_0 + 8'($urandom_range(0, 9)), 1'b0, '0);
      case ($urandom_range(0, 2))
        0: ;
        1: send_byte(CH_DOT, 1'b0, '0);
        default: begin
          send_byte(CH_DOT, 1'b0, '0);
          n = $urandom_range(1, 3);
          repeat (n) send_byte(CH_0 + 8'($urandom_range(0, 9)), 1'b0, '0);
        end
      endcase
    end else if (pick < 55) begin
      send_byte(CH_QUOTE, 1'b0, '0);
      n = $urandom_range(0, 6);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) begin
          b = CH_LF;
        end else begin
          do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE);
        end
        send_byte(b, 1'b0, '0);
      end
      // now and then the string is left open
      if ($urandom_range(0, 9) != 0) send_byte(CH_QUOTE, 1'b0, '0);
    end else if (pick < 63) begin
      send_byte(CH_SLASH, 1'b0, '0);
      send_byte(CH_SLASH, 1'b0, '0);
      n = $urandom_range(0, 5);
      repeat (n) begin
        do b = 8'($urandom_range(1, 255)); while (b == CH_LF);
        send_byte(b, 1'b0, '0);
      end
      send_byte(CH_LF, 1'b0, '0);
    end else if (pick < 78) begin
      case ($urandom_range(0, 3))
        0: send_byte(CH_SPACE, 1'b0, '0);
        1: send_byte(CH_TAB, 1'b0, '0);
        2: send_byte(CH_CR, 1'b0, '0);
        default: send_byte(CH_LF, 1'b0, '0);
      endcase
    end else if (pick < 90) begin
      send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
    end else if (pick < 94) begin
      send_byte(CH_NUL, 1'b0, '0);
    end else begin
      send_byte(8'($urandom_range(128, 255)), 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, and the checker
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else if ($urandom_range(0, 99) < sink_stall_pct) begin
      m_axis_tready <= 1'b0;
      sink_hold     <= $urandom_range(0, 9);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_token.last = m_axis_tlast;
      seen_token.tok  = m_axis_tdata[52:0];
      if (expected_tokens.size() == 0) begin
        $display("%0t: token transfer, expected none, actual kind %0d start %0d",
                 $time, seen_token.tok.kind, seen_token.tok.start);
        fails++;
      end else begin
        want_token = expected_tokens.pop_front();
        check_field("kind", 32'(want_token.tok.kind), 32'(seen_token.tok.kind));
        check_field("start", 32'(want_token.tok.start), 32'(seen_token.tok.start));
        check_field("length", 32'(want_token.tok.length), 32'(seen_token.tok.length));
        check_field("line", 32'(want_token.tok.line), 32'(seen_token.tok.line));
        check_field("tlast", 32'(want_token.last), 32'(seen_token.last));
        check_field("pad", 32'd0, 32'(m_axis_tdata[55:53]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Run
  // ---------------------------------------------------------------------------

  initial begin
    token_t fixed_tok;
    int     next_shuffle;
    string  tail;
    reset_scanner();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    src_gap_pct    = 20;
    sink_stall_pct = 20;
    for (int r = 0; r < TABLE_ROWS; r++) begin
      fixed_tok.last       = 1'b1;
      fixed_tok.tok.kind   = STIM_TABLE[r[4:0]].kind;
      fixed_tok.tok.start  = STIM_TABLE[r[4:0]].start;
      fixed_tok.tok.length = STIM_TABLE[r[4:0]].length;
      fixed_tok.tok.line   = STIM_TABLE[r[4:0]].line;
      send_byte(STIM_TABLE[r[4:0]].ch, STIM_TABLE[r[4:0]].fixed, fixed_tok);
    end

    // hold the source off until every booked token has been seen
    s_axis_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);

    // random source text, idling rates reshuffled every 60 bytes
    next_shuffle = bytes_sent;
    while (bytes_sent < TABLE_ROWS + RANDOM_BYTES) begin
      if (bytes_sent >= TABLE_ROWS + RANDOM_BYTES - CALM_BYTES) begin
        src_gap_pct    = 0;
        sink_stall_pct = 0;
      end else if (bytes_sent >= next_shuffle) begin
        case ($urandom_range(0, 2))
          0: src_gap_pct = 0;
          1: src_gap_pct = 15;
          default: src_gap_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0: sink_stall_pct = 0;
          1: sink_stall_pct = 15;
          default: sink_stall_pct = 40;
        endcase
        next_shuffle = bytes_sent + 60;
      end
      send_lexeme();
    end
    send_byte(CH_NUL, 1'b0, '0);

    // short source packed with lookahead cases, ending on a pending operator
    tail = "12.+\"x\"!=/ 7(3.5;>";
    for (int n = 0; n < tail.len(); n++) send_byte(tail[n], 1'b0, '0);
    send_byte(CH_NUL, 1'b0, '0);
    s_axis_tvalid <= 1'b0;

    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
